>>> hdl/trp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants of the trapezoid ramp position step unit.
// ----------------------------------------------------------------------------
package trp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EPS,
        ST_KE,
        ST_KS,
        ST_GAP1,
        ST_GAP2,
        ST_VEL,
        ST_POS,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ACC_ZERO,
        ACC_POS,
        ACC_NEG
    } acc_sel_t;

    localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [1:0] REG_ACCEL_LIMIT = 2'd2;

    localparam logic [1:0] STATUS_MOVING  = 2'd0;
    localparam logic [1:0] STATUS_REACHED = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    localparam int MUL_W = 36;
    localparam int PROD_W = 2 * MUL_W;
    localparam logic [5:0] MUL_STEPS = 6'd36;

    localparam logic [23:0] TICK_PERIOD_RESET = 24'd16777;
    localparam logic [30:0] SPEED_LIMIT_RESET = 31'd65536;
    localparam logic [30:0] ACCEL_LIMIT_RESET = 31'd65536;

endpackage
`default_nettype wire

>>> hdl/trapezoid_ramp_position_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_ramp_position_step_unit
// One control tick of a trapezoidal velocity profile in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each transaction on the input stream is one control tick and yields one
// result transaction. All products go through a single shift-add multiplier
// that retires one multiplier bit per cycle. A tick needs two products (speed
// step, position step) when the acceleration follows from signs and limits
// alone, and six or seven products when the braking distance is compared with
// the remaining distance. A tick with a zero limit skips the multiplier and
// goes straight to the output. The next tick is taken while a finished result
// waits on the output.
module trapezoid_ramp_position_step_unit
    import trp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // target_position, target_end_speed
    input  wire logic [63:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // chosen_accel, new_speed, new_position, status, zero pad
    output logic [103:0]      m_tdata
);

    logic [23:0]        tick_reg;
    logic [30:0]        vmax_reg;
    logic [30:0]        amax_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] spd_reg;
    logic signed [31:0] acc_reg;
    logic [1:0]         st_reg;
    logic [1:0]         st_next;
    state_t             state_reg;
    state_t             state_next;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] e_reg;
    logic signed [32:0] dist_reg;
    logic signed [31:0] eps_reg;
    logic [63:0]        ke_reg;
    logic signed [63:0] kes_reg;
    logic               tge_reg;
    logic               nk_reg;
    acc_sel_t           sel1_reg;
    acc_sel_t           sel3_reg;
    acc_sel_t           sel_reg;
    acc_sel_t           sel_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [MUL_W-1:0]   mcand_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic               m_tvalid_reg;
    logic [103:0]       m_tdata_reg;

    logic               ld;
    logic [MUL_W-1:0]   ld_a;
    logic [MUL_W-1:0]   ld_b;
    logic               ld_neg;
    logic               busy;
    logic               accept;
    logic               out_free;
    logic [MUL_W:0]     sum;
    logic signed [PROD_W:0] prod_sgn;

    logic signed [31:0] tgt_in;
    logic signed [31:0] e_in;
    logic signed [31:0] e_cl;
    logic signed [31:0] vmax_s;
    logic signed [31:0] amax_s;
    logic signed [32:0] dist_in;
    logic               need_gap;
    acc_sel_t           sel_d;
    acc_sel_t           sel1_d;
    acc_sel_t           sel3_d;
    logic               tge_d;
    logic               nk_d;

    logic signed [34:0] r1;
    logic signed [34:0] r2;
    logic signed [63:0] k;
    logic signed [69:0] g;
    logic               pass;
    logic signed [PROD_W:0] rnd;
    logic signed [31:0] ns;
    logic signed [31:0] np;
    logic               reached;

    function automatic logic [MUL_W-1:0] mag32(logic signed [31:0] x);
        logic signed [32:0] w;
        w = {x[31], x};
        if (x[31])
        begin
            w = -w;
        end
        return {3'b000, w};
    endfunction

    function automatic logic [MUL_W-1:0] mag35(logic signed [34:0] x);
        logic signed [35:0] w;
        w = {x[34], x};
        if (x[34])
        begin
            w = -w;
        end
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [33:0] x);
        if (x > 34'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (x < -34'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] acc_val(acc_sel_t s, logic signed [31:0] a);
        logic signed [31:0] v;
        unique case (s)
            ACC_POS: v = a;
            ACC_NEG: v = -a;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign busy      = (cnt_reg != 6'd0);

    assign vmax_s  = {1'b0, vmax_reg};
    assign amax_s  = {1'b0, amax_reg};
    assign tgt_in  = s_tdata[31:0];
    assign e_in    = s_tdata[63:32];
    assign e_cl    = (e_in > vmax_s) ? vmax_s : ((e_in < -vmax_s) ? -vmax_s : e_in);
    assign dist_in = {tgt_in[31], tgt_in} - {pos_reg[31], pos_reg};

    assign sum = {1'b0, prod_reg[PROD_W-1:MUL_W]}
                 + (prod_reg[0] ? {1'b0, mcand_reg} : {(MUL_W+1){1'b0}});
    assign prod_sgn = neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});

    assign r1 = {{2{dist_reg[32]}}, dist_reg} - {{3{eps_reg[31]}}, eps_reg};
    assign r2 = r1 - {{3{eps_reg[31]}}, eps_reg};
    assign k  = nk_reg ? -kes_reg : kes_reg;
    assign g  = {{6{k[63]}}, k} - prod_sgn[69:0];
    assign pass = tge_reg ? !g[69] : (g[69] || (g == 70'sd0));
    assign rnd  = (prod_sgn + (PROD_W+1)'(25'sd8388608)) >>> 24;
    assign ns   = sat32({{2{spd_reg[31]}}, spd_reg} + rnd[33:0]);
    assign np   = sat32({{2{pos_reg[31]}}, pos_reg} + rnd[33:0]);
    assign reached = (tgt_reg == np) || ((tgt_reg > pos_reg) != (tgt_reg > np));

    // acceleration rule chosen from signs and limits, or the braking-distance test set up
    always_comb
    begin
        need_gap = 1'b0;
        sel_d    = ACC_ZERO;
        sel1_d   = ACC_ZERO;
        sel3_d   = ACC_ZERO;
        tge_d    = 1'b0;
        nk_d     = 1'b0;
        if (dist_in < 0 && spd_reg > 0)
        begin
            sel_d = ACC_NEG;
        end
        else if (dist_in > 0 && spd_reg < 0)
        begin
            sel_d = ACC_POS;
        end
        else if (dist_in < 0 && e_cl > 0)
        begin
            if (spd_reg < -vmax_s)
            begin
                sel_d = ACC_POS;
            end
            else
            begin
                need_gap = 1'b1;
                tge_d    = 1'b1;
                sel1_d   = (spd_reg > -vmax_s) ? ACC_NEG : ACC_ZERO;
                sel3_d   = ACC_POS;
            end
        end
        else if (dist_in > 0 && e_cl < 0)
        begin
            if (spd_reg > vmax_s)
            begin
                sel_d = ACC_NEG;
            end
            else
            begin
                need_gap = 1'b1;
                nk_d     = 1'b1;
                sel1_d   = (spd_reg < vmax_s) ? ACC_POS : ACC_ZERO;
                sel3_d   = ACC_NEG;
            end
        end
        else if (dist_in < 0)
        begin
            if (spd_reg < -vmax_s)
            begin
                sel_d = ACC_POS;
            end
            else if (spd_reg > e_cl)
            begin
                sel_d = ACC_NEG;
            end
            else
            begin
                need_gap = 1'b1;
                sel1_d   = ACC_POS;
                sel3_d   = (spd_reg > -vmax_s) ? ACC_NEG : ACC_ZERO;
            end
        end
        else if (dist_in > 0)
        begin
            if (spd_reg > vmax_s)
            begin
                sel_d = ACC_NEG;
            end
            else if (spd_reg < e_cl)
            begin
                sel_d = ACC_POS;
            end
            else
            begin
                need_gap = 1'b1;
                tge_d    = 1'b1;
                nk_d     = 1'b1;
                sel1_d   = ACC_NEG;
                sel3_d   = (spd_reg < vmax_s) ? ACC_POS : ACC_ZERO;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        st_next    = st_reg;
        ld         = 1'b0;
        ld_a       = '0;
        ld_b       = '0;
        ld_neg     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (vmax_reg == 31'd0 || amax_reg == 31'd0)
                    begin
                        st_next    = STATUS_ERROR;
                        state_next = ST_OUT;
                    end
                    else if (need_gap)
                    begin
                        ld         = 1'b1;
                        ld_a       = mag32(spd_reg);
                        ld_b       = {12'd0, tick_reg};
                        ld_neg     = spd_reg[31];
                        state_next = ST_EPS;
                    end
                    else
                    begin
                        sel_next   = sel_d;
                        ld         = 1'b1;
                        ld_a       = (sel_d == ACC_ZERO) ? '0 : {5'd0, amax_reg};
                        ld_b       = {12'd0, tick_reg};
                        ld_neg     = (sel_d == ACC_NEG);
                        state_next = ST_VEL;
                    end
                end
            end
            ST_EPS:
            begin
                if (!busy)
                begin
                    ld         = 1'b1;
                    ld_a       = mag32(e_reg);
                    ld_b       = mag32(e_reg);
                    state_next = ST_KE;
                end
            end
            ST_KE:
            begin
                if (!busy)
                begin
                    ld         = 1'b1;
                    ld_a       = mag32(spd_reg);
                    ld_b       = mag32(spd_reg);
                    state_next = ST_KS;
                end
            end
            ST_KS:
            begin
                if (!busy)
                begin
                    ld         = 1'b1;
                    ld_a       = mag35(r1);
                    ld_b       = {4'd0, amax_reg, 1'b0};
                    ld_neg     = r1[34];
                    state_next = ST_GAP1;
                end
            end
            ST_GAP1:
            begin
                if (!busy)
                begin
                    ld = 1'b1;
                    if (pass)
                    begin
                        sel_next   = sel1_reg;
                        ld_a       = (sel1_reg == ACC_ZERO) ? '0 : {5'd0, amax_reg};
                        ld_b       = {12'd0, tick_reg};
                        ld_neg     = (sel1_reg == ACC_NEG);
                        state_next = ST_VEL;
                    end
                    else
                    begin
                        ld_a       = mag35(r2);
                        ld_b       = {4'd0, amax_reg, 1'b0};
                        ld_neg     = r2[34];
                        state_next = ST_GAP2;
                    end
                end
            end
            ST_GAP2:
            begin
                if (!busy)
                begin
                    sel_next   = pass ? ACC_ZERO : sel3_reg;
                    ld         = 1'b1;
                    ld_a       = (sel_next == ACC_ZERO) ? '0 : {5'd0, amax_reg};
                    ld_b       = {12'd0, tick_reg};
                    ld_neg     = (sel_next == ACC_NEG);
                    state_next = ST_VEL;
                end
            end
            ST_VEL:
            begin
                if (!busy)
                begin
                    ld         = 1'b1;
                    ld_a       = mag32(ns);
                    ld_b       = {12'd0, tick_reg};
                    ld_neg     = ns[31];
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (!busy)
                begin
                    st_next    = reached ? STATUS_REACHED : STATUS_MOVING;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= TICK_PERIOD_RESET;
            vmax_reg     <= SPEED_LIMIT_RESET;
            amax_reg     <= ACCEL_LIMIT_RESET;
            pos_reg      <= '0;
            spd_reg      <= '0;
            acc_reg      <= '0;
            st_reg       <= STATUS_MOVING;
            sel_reg      <= ACC_ZERO;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_TICK_PERIOD: tick_reg <= cfg_data[23:0];
                    REG_SPEED_LIMIT: vmax_reg <= cfg_data[30:0];
                    REG_ACCEL_LIMIT: amax_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            st_reg  <= st_next;
            sel_reg <= sel_next;
            if (ld)
            begin
                cnt_reg <= MUL_STEPS;
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (state_reg == ST_VEL && !busy)
            begin
                acc_reg <= acc_val(sel_reg, amax_s);
                spd_reg <= ns;
            end
            if (state_reg == ST_POS && !busy)
            begin
                pos_reg <= np;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tgt_reg  <= tgt_in;
            e_reg    <= e_cl;
            dist_reg <= dist_in;
            tge_reg  <= tge_d;
            nk_reg   <= nk_d;
            sel1_reg <= sel1_d;
            sel3_reg <= sel3_d;
        end
        if (state_reg == ST_EPS && !busy)
        begin
            eps_reg <= 32'(prod_sgn >>> 25);
        end
        if (state_reg == ST_KE && !busy)
        begin
            ke_reg <= prod_reg[63:0];
        end
        if (state_reg == ST_KS && !busy)
        begin
            kes_reg <= $signed(ke_reg - prod_reg[63:0]);
        end
        if (ld)
        begin
            prod_reg  <= {{MUL_W{1'b0}}, ld_b};
            mcand_reg <= ld_a;
            neg_reg   <= ld_neg;
        end
        else if (busy)
        begin
            prod_reg <= {sum, prod_reg[MUL_W-1:1]};
        end
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {6'd0, st_reg, pos_reg, spd_reg, acc_reg};
        end
    end

endmodule
`default_nettype wire

>>> hdl/trp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trp_checker
// Port-level checks of the trapezoid ramp position step unit.
// ----------------------------------------------------------------------------
module trp_checker
    import trp_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [1:0]   cfg_index,
    input wire logic [31:0]  cfg_data,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [63:0]  s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata
);

    logic unused;
    assign unused = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data) ^ (^s_tdata);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[97:96] == STATUS_MOVING || m_tdata[97:96] == STATUS_REACHED
                      || m_tdata[97:96] == STATUS_ERROR))
        else $error("bad status code");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second tick taken while busy");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind trapezoid_ramp_position_step_unit trp_checker u_trp_checker (.*);
`default_nettype wire

>>> sim/tb_trapezoid_ramp_position_step_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trapezoid_ramp_position_step_unit
// Self-checking bench: directed and random control ticks are sent through
// the input stream, each result is compared with an in-bench profile model
// over a series of register settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_trapezoid_ramp_position_step_unit;
    import trp_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic signed [31:0] accel;
    } tick_result_t;

    // tracks the motion state and the expected tick results
    class tick_scoreboard;
        longint unsigned period;
        longint          vmax;
        longint          amax;
        longint          pos;
        longint          spd;
        longint          acc_q;
        tick_result_t    pending[$];
        int              errors;

        function new();
            period = TICK_PERIOD_RESET;
            vmax   = SPEED_LIMIT_RESET;
            amax   = ACCEL_LIMIT_RESET;
            pos    = 0;
            spd    = 0;
            acc_q  = 0;
            errors = 0;
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q--;
            return q;
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function longint scale_dt(longint v);
            return floor_div(v * longint'(period) + (64'sd1 <<< 23), 64'sd1 <<< 24);
        endfunction

        // sign of k - a2*r without rounding
        function int gap_sign(longint k, longint a2, longint r);
            longint q;
            longint rem;
            q = floor_div(k, a2);
            rem = k - q * a2;
            if (q > r)
                return 1;
            if (q < r)
                return -1;
            return (rem > 0) ? 1 : 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_TICK_PERIOD: period = val[23:0];
                REG_SPEED_LIMIT: vmax = val[30:0];
                REG_ACCEL_LIMIT: amax = val[30:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic signed [31:0] tgt_in, logic signed [31:0] end_in);
            longint tgt;
            longint e;
            longint s;
            longint remaining;
            longint eps;
            longint a2;
            longint kes;
            longint a;
            longint acc;
            longint ns;
            longint np;
            bit ahead;
            bit ahead_after;
            tick_result_t r;
            tgt = tgt_in;
            e = end_in;
            s = spd;
            a = amax;
            if (vmax == 0 || amax == 0)
            begin
                r.accel = acc_q;
                r.speed = spd;
                r.position = pos;
                r.status = STATUS_ERROR;
                pending.push_back(r);
                return;
            end
            if (e > vmax)
                e = vmax;
            else if (e < -vmax)
                e = -vmax;
            remaining = tgt - pos;
            eps = floor_div(s * longint'(period), 64'sd1 <<< 25);
            a2 = 2 * a;
            kes = e * e - s * s;
            if (remaining < 0 && s > 0)
                acc = -a;
            else if (remaining > 0 && s < 0)
                acc = a;
            else if (remaining < 0 && s <= 0 && e > 0)
            begin
                if (s < -vmax) acc = a;
                else if (gap_sign(kes, a2, remaining - eps) >= 0) acc = (s > -vmax) ? -a : 0;
                else if (gap_sign(kes, a2, remaining - 2 * eps) >= 0) acc = 0;
                else acc = a;
            end
            else if (remaining > 0 && s >= 0 && e < 0)
            begin
                if (s > vmax) acc = -a;
                else if (gap_sign(-kes, a2, remaining - eps) <= 0) acc = (s < vmax) ? a : 0;
                else if (gap_sign(-kes, a2, remaining - 2 * eps) <= 0) acc = 0;
                else acc = -a;
            end
            else if (remaining < 0 && s <= 0 && e <= 0)
            begin
                if (s < -vmax) acc = a;
                else if (s > e) acc = -a;
                else if (gap_sign(kes, a2, remaining - eps) <= 0) acc = a;
                else if (gap_sign(kes, a2, remaining - 2 * eps) <= 0) acc = 0;
                else acc = (s > -vmax) ? -a : 0;
            end
            else if (remaining > 0 && s >= 0 && e >= 0)
            begin
                if (s > vmax) acc = -a;
                else if (s < e) acc = a;
                else if (gap_sign(-kes, a2, remaining - eps) >= 0) acc = -a;
                else if (gap_sign(-kes, a2, remaining - 2 * eps) >= 0) acc = 0;
                else acc = (s < vmax) ? a : 0;
            end
            else
                acc = 0;
            ns = clip32(s + scale_dt(acc));
            np = clip32(pos + scale_dt(ns));
            ahead = tgt > pos;
            ahead_after = tgt > np;
            r.status = (tgt == np || ahead != ahead_after) ? STATUS_REACHED : STATUS_MOVING;
            r.accel = acc;
            r.speed = ns;
            r.position = np;
            acc_q = acc;
            spd = ns;
            pos = np;
            pending.push_back(r);
        endfunction

        task check_result(logic [103:0] data);
            tick_result_t got;
            tick_result_t want;
            got = data[97:0];
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, got.accel);
                return;
            end
            want = pending.pop_front();
            if (got.accel !== want.accel)
                report_mismatch("chosen_accel", want.accel, got.accel);
            if (got.speed !== want.speed)
                report_mismatch("new_speed", want.speed, got.speed);
            if (got.position !== want.position)
                report_mismatch("new_position", want.position, got.position);
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
        endtask

        task report_mismatch(string what, longint want, longint got);
            errors++;
            if (errors <= 40)
                $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // target_position, target_end_speed
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // chosen_accel, new_speed, new_position, status, zero pad
    logic [103:0] m_tdata;

    tick_scoreboard board;
    int burst_left;
    int stall_mode;

    trapezoid_ramp_position_step_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        board = new();
    end

    // checks each result and drives the output stall pattern, which changes mode now and then
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(logic [31:0] tgt, logic [31:0] spd_end);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {spd_end, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_tick(tgt, spd_end);
    endtask

    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65536 * 4) - 32'd131072;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(int n);
        logic [31:0] tgt;
        logic [31:0] ve;
        int left;
        left = 0;
        for (int i = 0; i < n; i++)
        begin
            // mostly hold one goal for many ticks so the ramp plays out
            if (left == 0 || $urandom_range(0, 49) == 0)
            begin
                left = $urandom_range(5, 120);
                tgt = ($urandom_range(0, 3) == 0) ? rand_word()
                    : $urandom_range(0, 32'h00400000) - 32'h00200000;
                ve = ($urandom_range(0, 2) == 0) ? rand_word()
                    : $urandom_range(0, 32'h40000) - 32'h20000;
            end
            left--;
            send_tick(tgt, ve);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TICK_PERIOD;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        stall_mode = 0;
        burst_left = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks at reset settings
        send_tick(32'h7fffffff, 32'h7fffffff);
        send_tick(32'h80000000, 32'h80000000);
        send_tick(32'h00000000, 32'h00000000);
        send_tick(32'h00010000, 32'hffff0000);
        send_tick(32'hffff0000, 32'h00010000);
        send_tick(32'h00000000, 32'h00000000);
        drain();
        write_reg(REG_TICK_PERIOD, 32'h00ffffff);
        write_reg(REG_SPEED_LIMIT, 32'h7fffffff);
        write_reg(REG_ACCEL_LIMIT, 32'h7fffffff);
        send_tick(32'h7fffffff, 32'h00000000);
        send_tick(32'h7fffffff, 32'h00000000);
        send_tick(32'h80000000, 32'h7fffffff);
        send_tick(32'h80000000, 32'h80000000);
        send_tick(32'h00000000, 32'h00000000);
        drain();
        // speed over a freshly lowered limit
        write_reg(REG_SPEED_LIMIT, 32'h00000100);
        send_tick(32'h12345678, 32'h00000000);
        send_tick(32'h80000000, 32'h00000000);
        drain();
        write_reg(REG_SPEED_LIMIT, 32'h00000000);
        send_tick(32'h00001000, 32'h00001000);
        drain();
        write_reg(REG_SPEED_LIMIT, 32'h00010000);
        write_reg(REG_ACCEL_LIMIT, 32'h00000000);
        send_tick(32'hfffff000, 32'h00000000);
        drain();
        write_reg(REG_ACCEL_LIMIT, 32'h00010000);
        write_reg(REG_TICK_PERIOD, 32'h00000000);
        send_tick(32'h00100000, 32'h00000000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_TICK_PERIOD, (ph == 0) ? 32'd1 : (ph == 1) ? 32'hffffff
                : $urandom_range(1000, 400000));
            write_reg(REG_SPEED_LIMIT, (ph == 2) ? 32'h7fffffff : (ph == 3) ? 32'd1
                : $urandom_range(1 << 14, 1 << 20));
            write_reg(REG_ACCEL_LIMIT, (ph == 4) ? 32'h7fffffff : (ph == 5) ? 32'd1
                : $urandom_range(1 << 14, 1 << 21));
            run_phase(200);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
hdl/trp_pkg.sv
hdl/trapezoid_ramp_position_step_unit.sv
hdl/trp_checker.sv
sim/tb_trapezoid_ramp_position_step_unit.sv
